### hw/rtl/chs_pkg.sv
// Shared types and constants for the clocked serial host slave.
`default_nettype none

package chs_pkg;

  // Item modes
  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;
  localparam logic [1:0] MODE_TAKE = 2'd3;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_TICK_SAT = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET  = 8'd10;
  localparam logic [7:0] TICK_SAT_RESET = 8'd255;

  // Request framing
  localparam logic [2:0] TOP_BIT      = 3'd7;
  localparam logic [7:0] READ_COMMAND = 8'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic       data_bit;
    logic [3:0] resp_index;
    logic [7:0] resp_byte;
  } chs_in_t;

  typedef struct packed {
    logic       data_out;
    logic       idle;
    logic       request_ready;
    logic       taken;
    logic [7:0] backlight_byte;
    logic [7:0] settings_byte;
  } chs_out_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [7:0] tick_saturation;
  } chs_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/chs_link.sv
// Link state of the serial slave: receive shifter, response transmitter, timeout.
`default_nettype none

module chs_link
  import chs_pkg::*;
#(
  parameter int unsigned RESPONSE_BYTES = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  chs_in_t  item_i,
  input  chs_cfg_t cfg_i,
  output chs_out_t res_o
);

  localparam int unsigned TxIdxW = (RESPONSE_BYTES > 1) ? $clog2(RESPONSE_BYTES) : 1;

  logic [7:0]        req_q [2];
  logic [7:0]        req_d [2];
  logic [2:0]        rx_bit_q, rx_bit_d;
  logic              rx_byte_q, rx_byte_d;
  logic              ready_q, ready_d;
  logic              read_q, read_d;
  logic              idle_q, idle_d;
  logic [7:0]        tick_q, tick_d;
  logic [7:0]        resp_q [RESPONSE_BYTES];
  logic [2:0]        tx_bit_q, tx_bit_d;
  logic [TxIdxW-1:0] tx_byte_q, tx_byte_d;
  logic              level_q, level_d;

  logic [7:0] shifted;
  logic [2:0] rx_bit_inc;
  logic [7:0] tick_inc;
  logic [7:0] tx_byte_val;
  logic       load_en;
  logic       taken;
  logic [7:0] first_byte, second_byte;

  // Decode a response load that lands inside the table
  assign load_en = step_i && (item_i.mode == MODE_LOAD)
                   && ({1'b0, item_i.resp_index} < 5'(RESPONSE_BYTES));

  assign shifted     = {req_q[rx_byte_q][6:0], item_i.data_bit};
  assign rx_bit_inc  = rx_bit_q + 3'd1;
  assign tick_inc    = (tick_q < cfg_i.tick_saturation) ? tick_q + 8'd1 : tick_q;
  assign tx_byte_val = resp_q[tx_byte_q];

  // Work out the next link state for one item
  always_comb begin
    req_d       = req_q;
    rx_bit_d    = rx_bit_q;
    rx_byte_d   = rx_byte_q;
    ready_d     = ready_q;
    read_d      = read_q;
    idle_d      = idle_q;
    tick_d      = tick_q;
    tx_bit_d    = tx_bit_q;
    tx_byte_d   = tx_byte_q;
    level_d     = level_q;
    taken       = 1'b0;
    first_byte  = 8'd0;
    second_byte = 8'd0;

    unique case (item_i.mode)
      MODE_EDGE: begin
        tick_d = 8'd0;
        idle_d = 1'b0;
        if (!read_q) begin
          if (rx_bit_inc == 3'd1 && shifted == READ_COMMAND) begin
            // Read command: drop the byte and start sending
            req_d[rx_byte_q] = 8'd0;
            read_d           = 1'b1;
            rx_bit_d         = 3'd0;
            rx_byte_d        = 1'b0;
          end else begin
            req_d[rx_byte_q] = shifted;
            rx_bit_d         = rx_bit_inc;
            if (rx_bit_inc == 3'd0) begin
              if (rx_byte_q) begin
                rx_byte_d = 1'b0;
                ready_d   = 1'b1;
                idle_d    = 1'b1;
              end else begin
                rx_byte_d = 1'b1;
              end
            end
          end
        end else begin
          // Drive the next response bit, MSB first
          level_d = tx_byte_val[TOP_BIT - tx_bit_q];
          if (tx_bit_q == TOP_BIT) begin
            tx_bit_d = 3'd0;
            if (tx_byte_q == TxIdxW'(RESPONSE_BYTES - 1)) begin
              tx_byte_d = '0;
              read_d    = 1'b0;
              idle_d    = 1'b1;
            end else begin
              tx_byte_d = tx_byte_q + TxIdxW'(1);
            end
          end else begin
            tx_bit_d = tx_bit_q + 3'd1;
          end
        end
      end
      MODE_TICK: begin
        tick_d = tick_inc;
        if (tick_inc == cfg_i.timeout_ticks) begin
          // Abandon the transfer, keep the ready flag and line level
          rx_bit_d  = 3'd0;
          rx_byte_d = 1'b0;
          tick_d    = 8'd0;
          read_d    = 1'b0;
          idle_d    = 1'b1;
          tx_bit_d  = 3'd0;
          tx_byte_d = '0;
          req_d[0]  = 8'd0;
          req_d[1]  = 8'd0;
        end
      end
      MODE_LOAD: begin
        // Table write handled by the response store below
      end
      MODE_TAKE: begin
        if (ready_q) begin
          taken       = 1'b1;
          first_byte  = req_q[0];
          second_byte = req_q[1];
          req_d[0]    = 8'd0;
          req_d[1]    = 8'd0;
          ready_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the link state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q[0]  <= 8'd0;
      req_q[1]  <= 8'd0;
      rx_bit_q  <= 3'd0;
      rx_byte_q <= 1'b0;
      ready_q   <= 1'b0;
      read_q    <= 1'b0;
      idle_q    <= 1'b1;
      tick_q    <= 8'd0;
      tx_bit_q  <= 3'd0;
      tx_byte_q <= '0;
      level_q   <= 1'b0;
    end else if (step_i) begin
      req_q     <= req_d;
      rx_bit_q  <= rx_bit_d;
      rx_byte_q <= rx_byte_d;
      ready_q   <= ready_d;
      read_q    <= read_d;
      idle_q    <= idle_d;
      tick_q    <= tick_d;
      tx_bit_q  <= tx_bit_d;
      tx_byte_q <= tx_byte_d;
      level_q   <= level_d;
    end
  end

  // Hold the response bytes loaded by software
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RESPONSE_BYTES; i++) begin
        resp_q[i] <= 8'd0;
      end
    end else if (load_en) begin
      resp_q[item_i.resp_index[TxIdxW-1:0]] <= item_i.resp_byte;
    end
  end

  // Result of this item, sampled after the update
  always_comb begin
    res_o.data_out       = level_d;
    res_o.idle           = idle_d;
    res_o.request_ready  = ready_d;
    res_o.taken          = taken;
    res_o.backlight_byte = first_byte;
    res_o.settings_byte  = second_byte;
  end

endmodule

`default_nettype wire

### hw/rtl/clocked_serial_host_slave.sv
// Top level of the clocked serial host slave: handshakes, registers, link core.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------
//   in       | input     | in_valid_i / in_stall_o   | chs_in_t
//   out      | output    | out_valid_o / out_stall_i | chs_out_t
//   config   | input     | psel, penable, pwrite     | pwdata[7:0]
//
// One item per cycle while the output is not stalled; a result passes from the input
// register through the link update into the result register.
// Reset is asynchronous and active low; it restores all link state, the valid flags
// and the configuration registers, but not the item payload registers.
// A stalled result holds; one further item waits in the input register meanwhile.
`default_nettype none

module clocked_serial_host_slave
  import chs_pkg::*;
#(
  parameter int unsigned RESPONSE_BYTES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  chs_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output chs_out_t              out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic     s1_valid_q;
  chs_in_t  s1_item_q;
  logic     out_valid_q;
  chs_out_t out_item_q;
  chs_out_t link_res;
  chs_cfg_t cfg_q;
  logic     fire;
  logic     in_accept;
  logic     cfg_write;
  logic     reg_index;

  // Process the held item when the result register is free or draining
  assign fire      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  chs_link #(
    .RESPONSE_BYTES(RESPONSE_BYTES)
  ) u_link (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(fire),
    .item_i(s1_item_q),
    .cfg_i (cfg_q),
    .res_o (link_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= link_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks   <= TIMEOUT_RESET;
      cfg_q.tick_saturation <= TICK_SAT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_TIMEOUT:  cfg_q.timeout_ticks   <= pwdata[7:0];
        REG_TICK_SAT: cfg_q.tick_saturation <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      REG_TIMEOUT:  prdata = {24'd0, cfg_q.timeout_ticks};
      REG_TICK_SAT: prdata = {24'd0, cfg_q.tick_saturation};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/chs_checker.sv
// Port-level checks for the clocked serial host slave, bound to the top level.
`default_nettype none

module chs_port_checker
  import chs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input chs_out_t out_item_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input never stalls while the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // A successful take leaves no request ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.taken |-> !out_item_o.request_ready)
    else $error("request still ready after take");

  // Request bytes appear only with a successful take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.taken
      |-> out_item_o.backlight_byte == 8'd0 && out_item_o.settings_byte == 8'd0)
    else $error("request bytes without take");

endmodule

bind clocked_serial_host_slave chs_port_checker u_chs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

`default_nettype wire
